### src/dlps_pkg.sv
// Types and constants shared by the dual-lane RGB LED pulse serializer.
package dlps_pkg;

  localparam int unsigned TICK_W   = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PIXEL_W  = 24;
  localparam int unsigned START_W  = 6;
  localparam int unsigned PBITS_W  = 5;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_PHASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_PHASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_PHASE = 2'd2;

  localparam logic [TICK_W-1:0] LOW_PHASE_RST  = 10'd38;
  localparam logic [TICK_W-1:0] DATA_PHASE_RST = 10'd110;
  localparam logic [TICK_W-1:0] HIGH_PHASE_RST = 10'd26;

  // Start frame FF FF FF 00 00 00: the first half is ones, the second zeros.
  localparam logic [START_W-1:0] START_BITS      = 6'd48;
  localparam logic [START_W-1:0] START_ONES_FROM = 6'd24;
  localparam logic [PBITS_W-1:0] PIXEL_BITS      = 5'd24;

  localparam logic ACTION_TICK = 1'b0;
  localparam logic ACTION_LOAD = 1'b1;

  typedef struct packed {
    logic       action;
    logic       send_start;
    logic [7:0] red_a;
    logic [7:0] green_a;
    logic [7:0] blue_a;
    logic [7:0] red_b;
    logic [7:0] green_b;
    logic [7:0] blue_b;
  } in_item_t;

  typedef struct packed {
    logic level_a;
    logic level_b;
    logic busy_res;
    logic load_rejected;
  } out_item_t;

endpackage

### src/dual_lane_rgb_led_pulse_serializer.sv
// Dual-lane one-wire RGB LED pulse serializer: tick/load datapath and output skid buffer.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o | in_data_i  (in_item_t)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (out_item_t)
//   cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// Every item, tick or load, has its result registered at the accept edge.
// The throughput of one item per cycle while in_ready_o is high is set by the single state update per item.
// After reset the lines read high, the phase registers hold 38/110/26 and nothing is queued.
// A stalled output holds its result; a two-entry output buffer lets one more item
// enter, then in_ready_o drops until the consumer drains.
module dual_lane_rgb_led_pulse_serializer
  import dlps_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [TICK_W-1:0]    cfg_data_i
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LOW  = 2'd1,
    PH_DATA = 2'd2,
    PH_HIGH = 2'd3
  } phase_e;

  logic [TICK_W-1:0]  low_len_q, data_len_q, high_len_q;
  logic [PIXEL_W-1:0] shift_a_q, shift_a_d, shift_b_q, shift_b_d;
  logic [START_W-1:0] start_left_q, start_left_d;
  logic [PBITS_W-1:0] pixel_left_q, pixel_left_d;
  phase_e             phase_q, phase_d;
  logic [TICK_W-1:0]  count_q, count_d;
  logic [1:0]         levels_q, levels_d;

  out_item_t res;
  out_item_t out_q, skid_q;
  logic      out_valid_q, skid_valid_q;

  logic              in_acc, out_acc, busy;
  logic              bit_a, bit_b;
  logic [TICK_W-1:0] len_raw, len, count_inc;

  assign in_ready_o  = !skid_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_q && out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign busy        = (phase_q != PH_IDLE);

  // Configuration registers; out-of-range indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_len_q  <= LOW_PHASE_RST;
      data_len_q <= DATA_PHASE_RST;
      high_len_q <= HIGH_PHASE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOW_PHASE:  low_len_q  <= cfg_data_i;
        CFG_DATA_PHASE: data_len_q <= cfg_data_i;
        CFG_HIGH_PHASE: high_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (phase_q)
      PH_LOW:  len_raw = low_len_q;
      PH_DATA: len_raw = data_len_q;
      default: len_raw = high_len_q;
    endcase
    // A zero length acts as one tick.
    len       = (len_raw == '0) ? TICK_W'(1) : len_raw;
    count_inc = count_q + TICK_W'(1);
  end

  always_comb begin
    if (start_left_q != '0) begin
      bit_a = (start_left_q > START_ONES_FROM);
      bit_b = bit_a;
    end else begin
      bit_a = shift_a_q[PIXEL_W-1];
      bit_b = shift_b_q[PIXEL_W-1];
    end
  end

  always_comb begin
    shift_a_d    = shift_a_q;
    shift_b_d    = shift_b_q;
    start_left_d = start_left_q;
    pixel_left_d = pixel_left_q;
    phase_d      = phase_q;
    count_d      = count_q;
    levels_d     = levels_q;
    res          = '0;

    if (in_data_i.action == ACTION_LOAD) begin
      if (busy) begin
        res.load_rejected = 1'b1;
      end else begin
        shift_a_d    = {in_data_i.red_a, in_data_i.green_a, in_data_i.blue_a};
        shift_b_d    = {in_data_i.red_b, in_data_i.green_b, in_data_i.blue_b};
        start_left_d = in_data_i.send_start ? START_BITS : '0;
        pixel_left_d = PIXEL_BITS;
        phase_d      = PH_LOW;
        count_d      = '0;
      end
    end else if (!busy) begin
      levels_d = 2'b11;
    end else begin
      unique case (phase_q)
        PH_LOW:  levels_d = 2'b00;
        PH_DATA: levels_d = {~bit_b, ~bit_a};
        default: levels_d = 2'b11;
      endcase
      count_d = count_inc;
      if (count_inc >= len) begin
        count_d = '0;
        if (phase_q == PH_HIGH) begin
          // End of the bit slot: retire one start or pixel bit.
          if (start_left_q != '0) begin
            start_left_d = start_left_q - START_W'(1);
          end else if (pixel_left_q != '0) begin
            pixel_left_d = pixel_left_q - PBITS_W'(1);
            shift_a_d    = {shift_a_q[PIXEL_W-2:0], 1'b0};
            shift_b_d    = {shift_b_q[PIXEL_W-2:0], 1'b0};
          end
          phase_d = (start_left_d == '0 && pixel_left_d == '0) ? PH_IDLE : PH_LOW;
        end else begin
          phase_d = phase_e'(phase_q + 2'd1);
        end
      end
    end

    res.level_a  = levels_d[0];
    res.level_b  = levels_d[1];
    res.busy_res = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      start_left_q <= '0;
      pixel_left_q <= '0;
      count_q      <= '0;
      levels_q     <= 2'b11;
      shift_a_q    <= '0;
      shift_b_q    <= '0;
    end else if (in_acc) begin
      phase_q      <= phase_d;
      start_left_q <= start_left_d;
      pixel_left_q <= pixel_left_d;
      count_q      <= count_d;
      levels_q     <= levels_d;
      shift_a_q    <= shift_a_d;
      shift_b_q    <= shift_b_d;
    end
  end

  // Output register plus skid entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_acc) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_acc || !out_valid_q) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_acc) begin
        out_q <= skid_q;
      end
    end else if (in_acc) begin
      if (out_acc || !out_valid_q) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid while output register empty");

  a_start_before_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_left_q != '0) |-> (pixel_left_q == PIXEL_BITS && phase_q != PH_IDLE))
    else $error("start frame pending without a full pixel queued");

  a_load_starts_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.action == ACTION_LOAD && phase_q == PH_IDLE)
      |=> (phase_q == PH_LOW && count_q == '0))
    else $error("accepted load did not open a bit slot");

  a_idle_means_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (start_left_q == '0 && pixel_left_q == '0))
    else $error("idle with bits still queued");

  // The counter resets once it reaches the phase length, which is at most all ones.
  a_count_below_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '1)
    else $error("phase counter overran");

endmodule

### tb/tb_dual_lane_rgb_led_pulse_serializer.sv
// Testbench for the dual-lane RGB LED pulse serializer: predicted line levels vs. DUT.
module tb_dual_lane_rgb_led_pulse_serializer;
  timeunit 1ns;
  timeprecision 1ps;

  import dlps_pkg::*;

  localparam int IDLE_PCT       = 27;
  localparam int HOLD_AT        = 380;
  localparam int HOLD_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int TAIL_CYCLES    = 8;

  // Index with no register behind it; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    SLOT_IDLE,
    SLOT_LOW,
    SLOT_DATA,
    SLOT_HIGH
  } slot_phase_e;

  class line_level_scoreboard;
    logic [TICK_W-1:0]  low_len;
    logic [TICK_W-1:0]  data_len;
    logic [TICK_W-1:0]  high_len;
    logic [PIXEL_W-1:0] pix_a;
    logic [PIXEL_W-1:0] pix_b;
    logic [START_W-1:0] start_left;
    logic [PBITS_W-1:0] pixel_left;
    slot_phase_e        phase;
    logic [TICK_W-1:0]  ticks_in_phase;
    logic [1:0]         levels;
    out_item_t          expected_levels_q[$];
    int                 mismatches;

    function new();
      low_len        = LOW_PHASE_RST;
      data_len       = DATA_PHASE_RST;
      high_len       = HIGH_PHASE_RST;
      pix_a          = '0;
      pix_b          = '0;
      start_left     = '0;
      pixel_left     = '0;
      phase          = SLOT_IDLE;
      ticks_in_phase = '0;
      levels         = 2'b11;
      mismatches     = 0;
    endfunction

    function void write_phase_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
      case (idx)
        CFG_LOW_PHASE:  low_len = val;
        CFG_DATA_PHASE: data_len = val;
        CFG_HIGH_PHASE: high_len = val;
        default: ;
      endcase
    endfunction

    function bit is_busy();
      return phase != SLOT_IDLE;
    endfunction

    function int levels_pending();
      return expected_levels_q.size();
    endfunction

    function void predict_levels(in_item_t it);
      logic              busy;
      logic              rejected;
      logic              bit_a;
      logic              bit_b;
      logic [TICK_W-1:0] len;
      out_item_t         exp_item;
      busy     = phase != SLOT_IDLE;
      rejected = 1'b0;
      if (it.action == ACTION_LOAD) begin
        if (busy) begin
          rejected = 1'b1;
        end else begin
          pix_a          = {it.red_a, it.green_a, it.blue_a};
          pix_b          = {it.red_b, it.green_b, it.blue_b};
          start_left     = it.send_start ? START_BITS : '0;
          pixel_left     = PIXEL_BITS;
          phase          = SLOT_LOW;
          ticks_in_phase = '0;
        end
      end else if (!busy) begin
        levels = 2'b11;
      end else begin
        // Start frame: ones while more than half of it remains, zeros after.
        if (start_left != '0) begin
          bit_a = start_left > START_ONES_FROM;
          bit_b = bit_a;
        end else begin
          bit_a = pix_a[PIXEL_W-1];
          bit_b = pix_b[PIXEL_W-1];
        end
        case (phase)
          SLOT_LOW:  levels = 2'b00;
          SLOT_DATA: levels = {~bit_b, ~bit_a};
          default:   levels = 2'b11;
        endcase
        ticks_in_phase = ticks_in_phase + 1'b1;
        case (phase)
          SLOT_LOW:  len = low_len;
          SLOT_DATA: len = data_len;
          default:   len = high_len;
        endcase
        if (len == '0) len = TICK_W'(1);
        if (ticks_in_phase >= len) begin
          ticks_in_phase = '0;
          if (phase == SLOT_HIGH) begin
            if (start_left != '0) begin
              start_left = start_left - 1'b1;
            end else if (pixel_left != '0) begin
              pixel_left = pixel_left - 1'b1;
              pix_a      = pix_a << 1;
              pix_b      = pix_b << 1;
            end
            phase = (start_left == '0 && pixel_left == '0) ? SLOT_IDLE : SLOT_LOW;
          end else begin
            phase = slot_phase_e'(phase + 2'd1);
          end
        end
      end
      exp_item.level_a       = levels[0];
      exp_item.level_b       = levels[1];
      exp_item.busy_res      = phase != SLOT_IDLE;
      exp_item.load_rejected = rejected;
      expected_levels_q.push_back(exp_item);
    endfunction

    function void check_levels(out_item_t got);
      out_item_t exp_item;
      if (expected_levels_q.size() == 0) begin
        $error("unexpected result item %b", got);
        mismatches++;
        return;
      end
      exp_item = expected_levels_q.pop_front();
      if (got.level_a !== exp_item.level_a) begin
        $error("level_a: expected %0b, actual %0b", exp_item.level_a, got.level_a);
        mismatches++;
      end
      if (got.level_b !== exp_item.level_b) begin
        $error("level_b: expected %0b, actual %0b", exp_item.level_b, got.level_b);
        mismatches++;
      end
      if (got.busy_res !== exp_item.busy_res) begin
        $error("busy_res: expected %0b, actual %0b", exp_item.busy_res, got.busy_res);
        mismatches++;
      end
      if (got.load_rejected !== exp_item.load_rejected) begin
        $error("load_rejected: expected %0b, actual %0b",
               exp_item.load_rejected, got.load_rejected);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_item_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_item_t            out_data_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [TICK_W-1:0]    cfg_data_i;

  line_level_scoreboard sb;
  bit                   no_idle;
  int                   results_seen;
  int                   quiet_cycles;

  dual_lane_rgb_led_pulse_serializer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic in_item_t make_item(logic action, logic send_start,
                                         logic [PIXEL_W-1:0] pa, logic [PIXEL_W-1:0] pb);
    in_item_t it;
    it.action     = action;
    it.send_start = send_start;
    {it.red_a, it.green_a, it.blue_a} = pa;
    {it.red_b, it.green_b, it.blue_b} = pb;
    return it;
  endfunction

  // Present one item on a falling edge, hold it until accepted.
  task automatic send_item(input in_item_t it);
    @(negedge clk_i);
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.predict_levels(it);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic drain_levels();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.levels_pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_phase_reg(idx, val);
  endtask

  task automatic set_phases(input logic [TICK_W-1:0] lo, input logic [TICK_W-1:0] da,
                            input logic [TICK_W-1:0] hi);
    drain_levels();
    write_reg(CFG_LOW_PHASE, lo);
    write_reg(CFG_DATA_PHASE, da);
    write_reg(CFG_HIGH_PHASE, hi);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly whole frames: load when idle, tick while busy, a few stray loads and idle ticks.
  task automatic run_frames(input int count, input bit force_start);
    logic [63:0] r;
    in_item_t    it;
    bit          want_start;
    want_start = force_start;
    for (int k = 0; k < count; k++) begin
      r  = {$urandom(), $urandom()};
      it = r[$bits(in_item_t)-1:0];
      if (!sb.is_busy()) begin
        it.action = ($urandom_range(99) < 85) ? ACTION_LOAD : ACTION_TICK;
        if (it.action == ACTION_LOAD) begin
          it.send_start = want_start ? 1'b1 : ($urandom_range(99) < 30);
          want_start    = 1'b0;
        end
      end else begin
        it.action = ($urandom_range(99) < 5) ? ACTION_LOAD : ACTION_TICK;
      end
      send_item(it);
    end
  endtask

  // Receiver: random stalls, one long hold-off to back the block up.
  initial begin
    bit held;
    held        = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_ready_i <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_levels(out_data_o);
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    sb           = new();
    no_idle      = 1'b0;
    results_seen = 0;
    quiet_cycles = 0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_LOW_PHASE;
    cfg_data_i   = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset timing: idle tick, load, a few ticks, load while busy.
    send_item(make_item(ACTION_TICK, 1'b1, 24'hFFFFFF, 24'hFFFFFF));
    send_item(make_item(ACTION_LOAD, 1'b0, 24'hFFFFFF, 24'h000000));
    repeat (3) send_item(make_item(ACTION_TICK, 1'b0, 24'h000000, 24'h000000));
    send_item(make_item(ACTION_LOAD, 1'b1, 24'h000000, 24'hFFFFFF));
    repeat (2) send_item(make_item(ACTION_TICK, 1'b0, 24'h000000, 24'h000000));

    // Shrink phases mid-slot; zero length acts as one tick; unused index ignored.
    set_phases(10'd0, 10'd1, 10'd1);
    write_reg(CFG_UNUSED, 10'd1023);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    repeat (12) send_item(make_item(ACTION_TICK, 1'b0, 24'h000000, 24'h000000));
    run_frames(220, 1'b1);

    set_phases(10'd1023, 10'd1023, 10'd1023);
    run_frames(30, 1'b0);

    set_phases(10'd1, 10'd1, 10'd1);
    no_idle = 1'b1;
    run_frames(80, 1'b0);
    no_idle = 1'b0;

    set_phases(10'd1, 10'd2, 10'd1);
    run_frames(100, 1'b0);

    drain_levels();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
